// ===== rtl/core/rtcst_pkg.sv =====
`timescale 1ns / 1ps

package rtcst_pkg;

    // Field and datapath widths
    localparam int BYTE_W    = 8;
    localparam int YEAR_W    = 15;
    localparam int MONTH_W   = 4;
    localparam int QUOT_W    = 9;
    localparam int LEAPS_W   = 13;
    localparam int N365_W    = 24;
    localparam int MSD_W     = 9;
    localparam int DAYS_W    = 25;
    localparam int HOURS_W   = 30;
    localparam int MINS_W    = 36;
    localparam int SECS_W    = 42;
    localparam int SECS_C_W  = 39;
    localparam int SPLIT_W   = 20;
    localparam int TPS_W     = 24;
    localparam int PP_W      = 44;
    localparam int TICKS_W   = 62;
    localparam int LATENCY   = 9;

    localparam logic [YEAR_W-1:0]   EPOCH_YEAR    = 15'd1600;
    localparam logic [TPS_W-1:0]    TICKS_PER_SEC = 24'd10000000;
    // largest second count whose tick count still fits in TICKS_W bits
    localparam logic [SECS_C_W-1:0] SECS_MAX      = 39'd461168601842;
    localparam logic [TICKS_W-1:0]  TICKS_MAX     = '1;

    // Configuration register indexes
    localparam logic CFG_BCD_MODE        = 1'b0;
    localparam logic CFG_TWELVE_HOUR     = 1'b1;

    // Stage 1 result: decoded register bytes
    typedef struct packed {
        logic                invalid;
        logic [BYTE_W-1:0]   second;
        logic [BYTE_W-1:0]   minute;
        logic [BYTE_W-1:0]   hour;
        logic [BYTE_W-1:0]   day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } rtcst_dec_t;

    // Stage 3 result: day count, two's complement
    typedef struct packed {
        logic                invalid;
        logic [DAYS_W-1:0]   days;
        logic [BYTE_W-1:0]   hour;
        logic [BYTE_W-1:0]   minute;
        logic [BYTE_W-1:0]   second;
    } rtcst_days_t;

    // Stage 6 result: second count, two's complement
    typedef struct packed {
        logic                invalid;
        logic [SECS_W-1:0]   secs;
    } rtcst_secs_t;

    // BCD or binary byte decode; nibbles above 9 are not checked
    function automatic logic [BYTE_W-1:0] decode_byte(input logic [BYTE_W-1:0] raw,
                                                      input logic bcd);
        logic [BYTE_W-1:0] tens;
        tens = BYTE_W'({4'd0, raw[7:4]} * 8'd10);
        if (bcd)
            return tens + {4'd0, raw[3:0]};
        return raw;
    endfunction

    // floor(x / 100) by reciprocal multiply, exact for any 15-bit x
    function automatic logic [QUOT_W-1:0] div100(input logic [YEAR_W-1:0] x);
        logic [27:0] prod;
        prod = {13'd0, x} * 28'd5243;
        return prod[27:19];
    endfunction

    // Days before the first of the month in a common year
    function automatic logic [MSD_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [MSD_W-1:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/rtcst_decode.sv =====
`timescale 1ns / 1ps

module rtcst_decode (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       bcd_mode,
    input  logic                       twelve_hour_mode,
    input  logic [7:0]                 second_raw,
    input  logic [7:0]                 minute_raw,
    input  logic [7:0]                 hour_raw,
    input  logic [7:0]                 day_raw,
    input  logic [7:0]                 month_raw,
    input  logic [7:0]                 year_raw,
    input  logic [7:0]                 century_raw,
    output logic                       dec_valid,
    output rtcst_pkg::rtcst_dec_t      dec
);
    import rtcst_pkg::*;

    logic              valid_reg;
    rtcst_dec_t        dec_reg;
    rtcst_dec_t        dec_next;
    logic [BYTE_W-1:0] hour_d;
    logic [BYTE_W-1:0] month_d;
    logic [YEAR_W-1:0] year_d;

    // Hour: 12-hour form maps 12 to 0, then PM adds 12
    always_comb
    begin
        if (twelve_hour_mode)
        begin
            hour_d = decode_byte({1'b0, hour_raw[6:0]}, bcd_mode);
            if (hour_d == 8'd12)
                hour_d = '0;
            if (hour_raw[7])
                hour_d = hour_d + 8'd12;
        end
        else
        begin
            hour_d = decode_byte(hour_raw, bcd_mode);
        end
    end

    // Remaining fields, full year and range check
    always_comb
    begin
        month_d = decode_byte(month_raw, bcd_mode);
        year_d  = {7'd0, decode_byte(year_raw, bcd_mode)}
                + {7'd0, decode_byte(century_raw, bcd_mode)} * 15'd100;
        dec_next.second  = decode_byte(second_raw, bcd_mode);
        dec_next.minute  = decode_byte(minute_raw, bcd_mode);
        dec_next.hour    = hour_d;
        dec_next.day     = decode_byte(day_raw, bcd_mode);
        dec_next.month   = month_d[MONTH_W-1:0];
        dec_next.year    = year_d;
        dec_next.invalid = (month_d == 8'd0) || (month_d > 8'd12) || (year_d < EPOCH_YEAR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

    assign dec_valid = valid_reg;
    assign dec       = dec_reg;

endmodule

// ===== rtl/core/rtcst_date.sv =====
`timescale 1ns / 1ps

module rtcst_date (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       dec_valid,
    input  rtcst_pkg::rtcst_dec_t      dec,
    output logic                       days_valid,
    output rtcst_pkg::rtcst_days_t     days
);
    import rtcst_pkg::*;

    // Stage 2 registers
    logic               valid2_reg;
    logic [YEAR_W-1:0]  n_reg;
    logic [YEAR_W-1:0]  n_next;
    logic [N365_W-1:0]  n365_reg;
    logic [N365_W-1:0]  n365_next;
    logic [QUOT_W-1:0]  qn_reg;
    logic [QUOT_W-1:0]  qn_next;
    logic [QUOT_W-1:0]  qa_reg;
    logic [QUOT_W-1:0]  qa_next;
    logic [QUOT_W-1:0]  qb_reg;
    logic [QUOT_W-1:0]  qb_next;
    rtcst_dec_t         dec2_reg;

    // Stage 3 registers
    logic               valid3_reg;
    rtcst_days_t        days_reg;
    rtcst_days_t        days_next;

    logic [LEAPS_W-1:0] q4;
    logic [LEAPS_W-1:0] leaps;
    logic               cent;
    logic               leap_year;
    logic [DAYS_W-1:0]  days_u;

    // Years since epoch, n*365 and the quotients for the leap count
    always_comb
    begin
        n_next    = dec.year - EPOCH_YEAR;
        n365_next = {9'd0, n_next} * 24'd365;
        qn_next   = div100(n_next);
        qa_next   = div100(n_next + 15'd99);
        qb_next   = div100(YEAR_W'((n_next + 15'd399) >> 2));
    end

    // Leap days before this year, leap test of this year, day count
    always_comb
    begin
        q4        = LEAPS_W'((n_reg + 15'd3) >> 2);
        leaps     = q4 - LEAPS_W'(qa_reg) + LEAPS_W'(qb_reg);
        cent      = (n_reg == YEAR_W'({6'd0, qn_reg} * 15'd100));
        leap_year = (n_reg[1:0] == 2'd0) && (!cent || (qn_reg[1:0] == 2'd0));
        days_u    = DAYS_W'(n365_reg) + DAYS_W'(leaps)
                  + DAYS_W'(month_start(dec2_reg.month))
                  + DAYS_W'(leap_year && (dec2_reg.month > 4'd2))
                  + DAYS_W'(dec2_reg.day);
        days_next.invalid = dec2_reg.invalid;
        days_next.days    = days_u - 25'd1;
        days_next.hour    = dec2_reg.hour;
        days_next.minute  = dec2_reg.minute;
        days_next.second  = dec2_reg.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            valid2_reg <= dec_valid;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        n365_reg <= n365_next;
        qn_reg   <= qn_next;
        qa_reg   <= qa_next;
        qb_reg   <= qb_next;
        dec2_reg <= dec;
        days_reg <= days_next;
    end

    assign days_valid = valid3_reg;
    assign days       = days_reg;

endmodule

// ===== rtl/core/rtcst_secs.sv =====
`timescale 1ns / 1ps

module rtcst_secs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       days_valid,
    input  rtcst_pkg::rtcst_days_t     days,
    output logic                       secs_valid,
    output rtcst_pkg::rtcst_secs_t     secs
);
    import rtcst_pkg::*;

    // Stage 4: hours
    logic                       valid4_reg;
    logic signed [HOURS_W-1:0]  hours_reg;
    logic signed [HOURS_W-1:0]  hours_next;
    logic [BYTE_W-1:0]          minute4_reg;
    logic [BYTE_W-1:0]          second4_reg;
    logic                       invalid4_reg;

    // Stage 5: minutes
    logic                       valid5_reg;
    logic signed [MINS_W-1:0]   mins_reg;
    logic signed [MINS_W-1:0]   mins_next;
    logic [BYTE_W-1:0]          second5_reg;
    logic                       invalid5_reg;

    // Stage 6: seconds
    logic                       valid6_reg;
    rtcst_secs_t                secs_reg;
    rtcst_secs_t                secs_next;
    logic signed [SECS_W-1:0]   secs_s;

    // One multiply-add per stage, sign carried through
    always_comb
    begin
        hours_next = HOURS_W'($signed(days.days)) * 30'sd24
                   + signed'(HOURS_W'(days.hour));
        mins_next  = MINS_W'(hours_reg) * 36'sd60 + signed'(MINS_W'(minute4_reg));
        secs_s     = SECS_W'(mins_reg) * 42'sd60 + signed'(SECS_W'(second5_reg));
        secs_next.invalid = invalid5_reg;
        secs_next.secs    = secs_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
            valid6_reg <= 1'b0;
        end
        else
        begin
            valid4_reg <= days_valid;
            valid5_reg <= valid4_reg;
            valid6_reg <= valid5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hours_reg    <= hours_next;
        minute4_reg  <= days.minute;
        second4_reg  <= days.second;
        invalid4_reg <= days.invalid;
        mins_reg     <= mins_next;
        second5_reg  <= second4_reg;
        invalid5_reg <= invalid4_reg;
        secs_reg     <= secs_next;
    end

    assign secs_valid = valid6_reg;
    assign secs       = secs_reg;

endmodule

// ===== rtl/core/rtcst_scale.sv =====
`timescale 1ns / 1ps

module rtcst_scale (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       secs_valid,
    input  rtcst_pkg::rtcst_secs_t     secs,
    output logic                       done,
    output logic [61:0]                ticks,
    output logic                       invalid
);
    import rtcst_pkg::*;

    // Stage 7: clamp
    logic                   valid7_reg;
    logic [SECS_C_W-1:0]    secs_c_reg;
    logic [SECS_C_W-1:0]    secs_c_next;
    logic                   sat7_reg;
    logic                   sat7_next;
    logic                   invalid7_reg;
    logic                   neg;

    // Stage 8: partial products
    logic                   valid8_reg;
    logic [PP_W-1:0]        pp_lo_reg;
    logic [PP_W-1:0]        pp_lo_next;
    logic [PP_W-1:0]        pp_hi_reg;
    logic [PP_W-1:0]        pp_hi_next;
    logic                   sat8_reg;
    logic                   invalid8_reg;

    // Stage 9: output
    logic                   done_reg;
    logic [TICKS_W-1:0]     ticks_reg;
    logic [TICKS_W-1:0]     ticks_next;
    logic [TICKS_W-1:0]     sum;
    logic                   invalid_reg;

    // Negative counts go to zero, counts past the tick range saturate
    always_comb
    begin
        neg         = secs.secs[SECS_W-1];
        sat7_next   = !neg && (secs.secs > SECS_W'(SECS_MAX));
        secs_c_next = neg ? '0 : secs.secs[SECS_C_W-1:0];
    end

    // Seconds times ticks per second, split in two halves
    always_comb
    begin
        pp_lo_next = PP_W'(secs_c_reg[SPLIT_W-1:0]) * PP_W'(TICKS_PER_SEC);
        pp_hi_next = PP_W'(secs_c_reg[SECS_C_W-1:SPLIT_W]) * PP_W'(TICKS_PER_SEC);
    end

    always_comb
    begin
        sum = (TICKS_W'(pp_hi_reg) << SPLIT_W) + TICKS_W'(pp_lo_reg);
        if (invalid8_reg)
            ticks_next = '0;
        else if (sat8_reg)
            ticks_next = TICKS_MAX;
        else
            ticks_next = sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid7_reg <= 1'b0;
            valid8_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid7_reg <= secs_valid;
            valid8_reg <= valid7_reg;
            done_reg   <= valid8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        secs_c_reg   <= secs_c_next;
        sat7_reg     <= sat7_next;
        invalid7_reg <= secs.invalid;
        pp_lo_reg    <= pp_lo_next;
        pp_hi_reg    <= pp_hi_next;
        sat8_reg     <= sat7_reg;
        invalid8_reg <= invalid7_reg;
        ticks_reg    <= ticks_next;
        invalid_reg  <= invalid8_reg;
    end

    assign done    = done_reg;
    assign ticks   = ticks_reg;
    assign invalid = invalid_reg;

endmodule

// ===== rtl/core/rtc_fields_to_system_ticks.sv =====
`timescale 1ns / 1ps

// Clock-chip register bytes to 100 ns ticks since 1600-01-01 00:00:00.
// Input: pulse start with the seven raw bytes (second .. century) on the
// input ports; a transaction is taken at every edge with start high and busy
// low. busy never rises, so a new transaction may come in every cycle.
// Output: done is high for exactly one cycle with ticks and invalid valid in
// that cycle, once the transaction has left the last stage. Results come
// out in input order; the receiver cannot stall, so nothing is held back.
// Throughput is one transaction per cycle, set by the nine-stage pipeline:
// decode, date prep, day count, hours, minutes, seconds, clamp, split
// multiply by 10^7, final add.
// Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (0: bcd_mode, 1: twelve_hour_mode); cfg_ready is always high. Write only
// while no transaction is in flight.
// Reset: both mode bits return to 1 and the pipeline empties; no transaction
// in flight survives reset.
// A month outside 1..12 or a year below 1600 gives ticks 0 with invalid set.
module rtc_fields_to_system_ticks (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  second_raw,
    input  logic [7:0]  minute_raw,
    input  logic [7:0]  hour_raw,
    input  logic [7:0]  day_raw,
    input  logic [7:0]  month_raw,
    input  logic [7:0]  year_raw,
    input  logic [7:0]  century_raw,
    output logic        done,
    output logic [61:0] ticks,
    output logic        invalid,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data
);
    import rtcst_pkg::*;

    logic           bcd_mode_reg;
    logic           bcd_mode_next;
    logic           twelve_hour_mode_reg;
    logic           twelve_hour_mode_next;
    logic           in_valid;
    logic           dec_valid;
    rtcst_dec_t     dec;
    logic           days_valid;
    rtcst_days_t    days;
    logic           secs_valid;
    rtcst_secs_t    secs;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_valid  = start && !busy;

    // Mode registers
    always_comb
    begin
        bcd_mode_next         = bcd_mode_reg;
        twelve_hour_mode_next = twelve_hour_mode_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BCD_MODE:    bcd_mode_next         = cfg_data;
                CFG_TWELVE_HOUR: twelve_hour_mode_next = cfg_data;
                default:         bcd_mode_next         = bcd_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcd_mode_reg         <= 1'b1;
            twelve_hour_mode_reg <= 1'b1;
        end
        else
        begin
            bcd_mode_reg         <= bcd_mode_next;
            twelve_hour_mode_reg <= twelve_hour_mode_next;
        end
    end

    rtcst_decode u_decode (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .bcd_mode         (bcd_mode_reg),
        .twelve_hour_mode (twelve_hour_mode_reg),
        .second_raw       (second_raw),
        .minute_raw       (minute_raw),
        .hour_raw         (hour_raw),
        .day_raw          (day_raw),
        .month_raw        (month_raw),
        .year_raw         (year_raw),
        .century_raw      (century_raw),
        .dec_valid        (dec_valid),
        .dec              (dec)
    );

    rtcst_date u_date (
        .clk        (clk),
        .rst_n      (rst_n),
        .dec_valid  (dec_valid),
        .dec        (dec),
        .days_valid (days_valid),
        .days       (days)
    );

    rtcst_secs u_secs (
        .clk        (clk),
        .rst_n      (rst_n),
        .days_valid (days_valid),
        .days       (days),
        .secs_valid (secs_valid),
        .secs       (secs)
    );

    rtcst_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .secs_valid (secs_valid),
        .secs       (secs),
        .done       (done),
        .ticks      (ticks),
        .invalid    (invalid)
    );

    // Every accepted transaction yields a result after the pipeline latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##LATENCY done)
        else $error("result missing after pipeline latency");

    // No result without a transaction taken at the matching edge
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_valid, LATENCY))
        else $error("result without accepted transaction");

    // Invalid dates report zero ticks
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && invalid |-> ticks == '0)
        else $error("invalid date with nonzero ticks");

endmodule

// ===== bench/rtc_fields_to_system_ticks_tb.sv =====
`timescale 1ns / 1ps

module rtc_fields_to_system_ticks_tb;

    import rtcst_pkg::*;

    localparam int     CYCLE_LIMIT  = 200000;
    localparam longint TICK_CEIL    = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam longint TICKS_PER_S  = 10000000;
    localparam int     BASE_YEAR    = 1600;

    // One read of the clock chip register set
    typedef struct packed {
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year2;
        logic [7:0] century;
    } rtc_read_t;

    // Tick count the block must report for one read
    typedef struct packed {
        logic [TICKS_W-1:0] ticks;
        logic               invalid;
    } tick_count_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [7:0]         second_raw = '0;
    logic [7:0]         minute_raw = '0;
    logic [7:0]         hour_raw = '0;
    logic [7:0]         day_raw = '0;
    logic [7:0]         month_raw = '0;
    logic [7:0]         year_raw = '0;
    logic [7:0]         century_raw = '0;
    logic               done;
    logic [TICKS_W-1:0] ticks;
    logic               invalid;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic               cfg_data = 1'b0;

    // Our copy of the mode registers, as of reset
    bit          bcd_mode_q = 1'b1;
    bit          twelve_hour_q = 1'b1;

    rtc_read_t   rtc_reads_q[$];
    tick_count_t due_ticks_q[$];
    rtc_read_t   driven_read = '0;
    rtc_read_t   next_read;
    tick_count_t want;

    bit          idle_en = 1'b1;
    int          gap_left = 0;
    int          n_queued = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_fail = 0;
    int          n_invalid = 0;
    int          n_saturated = 0;
    int          n_settings = 1;
    int          cycle_cnt = 0;

    rtc_fields_to_system_ticks u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .second_raw  (second_raw),
        .minute_raw  (minute_raw),
        .hour_raw    (hour_raw),
        .day_raw     (day_raw),
        .month_raw   (month_raw),
        .year_raw    (year_raw),
        .century_raw (century_raw),
        .done        (done),
        .ticks       (ticks),
        .invalid     (invalid),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Register byte to value; BCD nibbles above 9 still weigh 10 and 1
    function automatic int unsigned byte_value(input logic [7:0] raw, input bit bcd);
        if (bcd)
            return 10 * 32'(raw[7:4]) + 32'(raw[3:0]);
        return 32'(raw);
    endfunction

    // Count of 100 ns ticks since 1600-01-01 00:00:00 for one register read
    function automatic tick_count_t ticks_since_epoch(input rtc_read_t r, input bit bcd,
                                                      input bit h12);
        int unsigned hr;
        int unsigned mo;
        int unsigned yr;
        longint      n;
        longint      leaps;
        longint      days;
        longint      secs;
        longint      tk;
        bit          leap_year;
        tick_count_t res;
        res = '0;
        if (h12)
        begin
            // 12 AM is hour 0, PM adds 12
            hr = byte_value({1'b0, r.hour[6:0]}, bcd);
            if (hr == 12)
                hr = 0;
            if (r.hour[7])
                hr += 12;
        end
        else
            hr = byte_value(r.hour, bcd);
        mo = byte_value(r.month, bcd);
        yr = byte_value(r.year2, bcd) + 100 * byte_value(r.century, bcd);
        if (mo < 1 || mo > 12 || yr < BASE_YEAR)
        begin
            res.invalid = 1'b1;
            return res;
        end
        // leap days over the whole years before this one
        n = longint'(yr) - BASE_YEAR;
        leaps = (n + 3) / 4 - (n + 99) / 100 + (n + 399) / 400;
        case (mo)
            2:       days = 31;
            3:       days = 59;
            4:       days = 90;
            5:       days = 120;
            6:       days = 151;
            7:       days = 181;
            8:       days = 212;
            9:       days = 243;
            10:      days = 273;
            11:      days = 304;
            12:      days = 334;
            default: days = 0;
        endcase
        leap_year = (yr % 100 == 0) ? (yr % 400 == 0) : (yr % 4 == 0);
        if (leap_year && mo > 2)
            days += 1;
        days = days + n * 365 + leaps + longint'(byte_value(r.day, bcd)) - 1;
        secs = ((days * 24 + longint'(hr)) * 60 + longint'(byte_value(r.minute, bcd))) * 60
             + longint'(byte_value(r.second, bcd));
        tk = secs * TICKS_PER_S;
        // clamp below zero and above the 62-bit range
        if (tk < 0)
            tk = 0;
        else if (tk > TICK_CEIL)
            tk = TICK_CEIL;
        res.ticks = tk[TICKS_W-1:0];
        return res;
    endfunction

    // Value to register byte under the current coding
    function automatic logic [7:0] to_byte(input int unsigned v);
        logic [3:0] tens;
        logic [3:0] ones;
        tens = 4'(v / 10);
        ones = 4'(v % 10);
        if (bcd_mode_q)
            return {tens, ones};
        return 8'(v);
    endfunction

    function automatic logic [7:0] to_hour_byte(input int unsigned hr);
        logic [7:0] b;
        if (!twelve_hour_q)
            return to_byte(hr);
        b = to_byte((hr % 12 == 0) ? 12 : hr % 12);
        return {hr >= 12, b[6:0]};
    endfunction

    task automatic add_read(input logic [7:0] s, input logic [7:0] m, input logic [7:0] h,
                            input logic [7:0] d, input logic [7:0] mo, input logic [7:0] y,
                            input logic [7:0] c);
        rtc_reads_q.push_back('{s, m, h, d, mo, y, c});
        n_queued++;
    endtask

    // Mostly plausible dates with random content, some broken dates, some noise
    task automatic add_random_reads(input int count);
        int        kind;
        int        yr;
        int        mo;
        int        dy;
        rtc_read_t r;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 12)
            begin
                r = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255))};
                r = {r[55:48] ^ 8'($urandom), r[47:0]};
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    yr = $urandom_range(BASE_YEAR, 2400);
                else
                    yr = $urandom_range(BASE_YEAR, bcd_mode_q ? 9999 : 25599);
                mo = $urandom_range(1, 12);
                dy = $urandom_range(1, 31);
                // around the leap day, century years included
                if ($urandom_range(0, 9) == 0)
                begin
                    yr = 4 * $urandom_range(400, 600);
                    mo = 2 + $urandom_range(0, 1);
                    dy = (mo == 2) ? 29 : 1;
                end
                if (kind < 24)
                begin
                    case ($urandom_range(0, 2))
                        0:       mo = 0;
                        1:       mo = $urandom_range(13, bcd_mode_q ? 99 : 255);
                        default: yr = $urandom_range(0, BASE_YEAR - 1);
                    endcase
                end
                r.second  = to_byte($urandom_range(0, 59));
                r.minute  = to_byte($urandom_range(0, 59));
                r.hour    = to_hour_byte($urandom_range(0, 23));
                r.day     = to_byte(dy);
                r.month   = to_byte(mo);
                r.year2   = to_byte(yr % 100);
                r.century = to_byte(yr / 100);
            end
            rtc_reads_q.push_back(r);
            n_queued++;
        end
    endtask

    // Block until every queued read is taken and its result checked
    task automatic wait_drained();
        do
            @(posedge clk);
        while (n_sent != n_queued || n_checked != n_queued);
    endtask

    task automatic write_mode(input logic idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_BCD_MODE)
            bcd_mode_q = val;
        else
            twelve_hour_q = val;
        @(posedge clk);
    endtask

    task automatic set_modes(input logic bcd, input logic h12);
        write_mode(CFG_BCD_MODE, bcd);
        write_mode(CFG_TWELVE_HOUR, h12);
        n_settings++;
    endtask

    // Driver: one register read per transaction, with random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                due_ticks_q.push_back(ticks_since_epoch(driven_read, bcd_mode_q,
                                                        twelve_hour_q));
                n_sent++;
            end
            if (start && busy)
            begin
                // held until taken
            end
            else if (gap_left != 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (rtc_reads_q.size() == 0)
                start <= 1'b0;
            else if (idle_en && $urandom_range(0, 9) == 0)
            begin
                start    <= 1'b0;
                gap_left <= $urandom_range(0, 15);
            end
            else
            begin
                next_read    = rtc_reads_q.pop_front();
                driven_read <= next_read;
                second_raw  <= next_read.second;
                minute_raw  <= next_read.minute;
                hour_raw    <= next_read.hour;
                day_raw     <= next_read.day;
                month_raw   <= next_read.month;
                year_raw    <= next_read.year2;
                century_raw <= next_read.century;
                start       <= 1'b1;
            end
        end
    end

    // Monitor: each done strobe against the oldest pending count
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (due_ticks_q.size() == 0)
            begin
                $error("unexpected result: ticks %0d invalid %0b", ticks, invalid);
                n_fail++;
            end
            else
            begin
                want = due_ticks_q.pop_front();
                if (ticks !== want.ticks)
                begin
                    $error("ticks: expected %0d, got %0d", want.ticks, ticks);
                    n_fail++;
                end
                if (invalid !== want.invalid)
                begin
                    $error("invalid: expected %0b, got %0b", want.invalid, invalid);
                    n_fail++;
                end
                if (want.invalid)
                    n_invalid++;
                if (want.ticks == TICK_CEIL[TICKS_W-1:0])
                    n_saturated++;
                n_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("rtc_fields_to_system_ticks_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset modes: BCD bytes, 12-hour clock
        add_read(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);   // month zero
        add_read(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);   // all ones
        add_read(8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h00, 8'h16);   // epoch, 12 AM
        add_read(8'h00, 8'h00, 8'h92, 8'h01, 8'h01, 8'h00, 8'h16);   // epoch, 12 PM
        add_read(8'h00, 8'h00, 8'h12, 8'h00, 8'h01, 8'h00, 8'h16);   // day 0, below zero
        add_read(8'h59, 8'h59, 8'h91, 8'h31, 8'h12, 8'h99, 8'h15);   // year 1599
        add_read(8'h00, 8'h00, 8'h01, 8'h01, 8'h13, 8'h24, 8'h20);   // month 13
        add_read(8'h59, 8'h59, 8'h91, 8'h29, 8'h02, 8'h24, 8'h20);   // leap day, 11 PM
        add_read(8'h00, 8'h00, 8'h01, 8'h01, 8'h03, 8'h24, 8'h20);   // after leap day
        add_read(8'h00, 8'h00, 8'h12, 8'h01, 8'h03, 8'h00, 8'h20);   // 2000 is leap
        add_read(8'h00, 8'h00, 8'h12, 8'h01, 8'h03, 8'h00, 8'h19);   // 1900 is not
        add_read(8'h00, 8'h00, 8'h12, 8'h01, 8'h03, 8'h00, 8'h21);   // 2100 is not
        add_read(8'h59, 8'h59, 8'h91, 8'h31, 8'h12, 8'h99, 8'h99);   // year 9999
        add_read(8'h59, 8'h59, 8'h91, 8'h31, 8'h12, 8'hFF, 8'hFF);   // saturates
        add_read(8'hAF, 8'hFA, 8'h05, 8'h3F, 8'h06, 8'h7A, 8'h1A);   // nibbles above 9
        add_read(8'h30, 8'h15, 8'h00, 8'h15, 8'h07, 8'h50, 8'h19);   // hour 0, AM
        add_read(8'h30, 8'h15, 8'h80, 8'h15, 8'h07, 8'h50, 8'h19);   // hour 0, PM
        add_read(8'h30, 8'h15, 8'h7F, 8'h15, 8'h07, 8'h50, 8'h19);   // hour 0x7F
        add_random_reads(100);
        // sender holds off until the pipeline has drained
        wait_drained();
        add_random_reads(80);
        wait_drained();

        // Binary bytes, 24-hour clock
        set_modes(1'b0, 1'b0);
        add_read(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);   // month 255
        add_read(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'hFF, 8'hFF);   // largest year
        add_read(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 8'd16);         // epoch
        add_read(8'd0, 8'd0, 8'h80, 8'd1, 8'd12, 8'd24, 8'd20);      // hour 128
        add_read(8'd0, 8'd0, 8'd12, 8'd29, 8'd2, 8'd0, 8'd20);       // noon, leap day
        add_random_reads(180);
        wait_drained();

        set_modes(1'b1, 1'b0);
        add_random_reads(180);
        wait_drained();

        set_modes(1'b0, 1'b1);
        add_random_reads(180);
        wait_drained();

        // Back to reset modes, back-to-back transactions
        set_modes(1'b1, 1'b1);
        idle_en = 1'b0;
        add_random_reads(180);
        wait_drained();
        repeat (LATENCY + 8) @(posedge clk);

        if (due_ticks_q.size() != 0)
        begin
            $error("%0d expected results never arrived", due_ticks_q.size());
            n_fail++;
        end
        $display("checked %0d register reads over %0d mode settings (BCD/binary, 12/24-hour)",
                 n_checked, n_settings);
        $display("of those, %0d invalid dates and %0d saturated counts", n_invalid,
                 n_saturated);
        if (n_fail == 0)
            $display("rtc_fields_to_system_ticks_tb OK");
        else
            $display("rtc_fields_to_system_ticks_tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rtcst_pkg.sv
rtl/core/rtcst_decode.sv
rtl/core/rtcst_date.sv
rtl/core/rtcst_secs.sv
rtl/core/rtcst_scale.sv
rtl/core/rtc_fields_to_system_ticks.sv
bench/rtc_fields_to_system_ticks_tb.sv
